[hdl/pmib_pkg.sv]
package pmib_pkg;

	localparam int MaxLen = 32;
	localparam int IdxW = 5;
	localparam int LenW = 6;
	localparam int CostW = 5;
	localparam int OutMax = 63;
	localparam int OutW = 6;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]       out_char;
		logic [CostW-1:0] insert_count;
		logic             out_last;
	} out_beat_t;

endpackage

[hdl/pmib_cost_ram.sv]
module pmib_cost_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [2*pmib_pkg::IdxW-1:0] wr_addr,
	input  logic [pmib_pkg::CostW-1:0]  wr_data,
	input  logic [2*pmib_pkg::IdxW-1:0] rd_addr,
	output logic [pmib_pkg::CostW-1:0]  rd_data
);

	logic [pmib_pkg::CostW-1:0] mem [0:(1<<(2*pmib_pkg::IdxW))-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[hdl/palindrome_min_insertion_builder.sv]
// Minimum-insertion palindrome builder.
// Input channel: one character per beat (in_char, in_last), valid/stall.
// Output channel: one palindrome character per beat with insert_count and
// out_last, valid/stall; the output register holds its beat while stalled.
// Loading takes one character per cycle; beats stream in while no string is
// being processed. After the last character the block fills the cost table
// by diagonals, each entry with two reads of the cost memory (separate read
// and write ports) and one write. It then reads the total count, the
// traceback picks one wrap character per step, and a build pass writes the
// palindrome into the result buffer at one character per cycle. Emission
// then sends one character per cycle while the receiver does not stall.
// Input stall is high from the last character until the final output beat
// is taken. A stall on the output simply holds the current beat and the
// emitter waits.
// Reset clears the string length and the control state; the stores are not
// cleared and are written before they are read for every string.
// Characters beyond 32 are dropped; a dropped beat with the last flag still
// starts processing of the stored string. An empty string yields no output.
module palindrome_min_insertion_builder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pmib_pkg::in_beat_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pmib_pkg::out_beat_t  out_data
);

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_F_RDX = 4'd1;
	localparam logic [3:0] ST_F_RDY = 4'd2;
	localparam logic [3:0] ST_F_WR = 4'd3;
	localparam logic [3:0] ST_CNT = 4'd4;
	localparam logic [3:0] ST_CNT2 = 4'd5;
	localparam logic [3:0] ST_T_RDX = 4'd6;
	localparam logic [3:0] ST_T_RDY = 4'd7;
	localparam logic [3:0] ST_T_DEC = 4'd8;
	localparam logic [3:0] ST_BUILD = 4'd9;
	localparam logic [3:0] ST_EMIT = 4'd10;

	localparam int IW = pmib_pkg::IdxW;
	localparam int CW = pmib_pkg::CostW;

	logic [3:0] state_q;
	logic [pmib_pkg::LenW-1:0] len_q;
	logic [IW-1:0] d_q, a_q, b_q;
	logic [CW-1:0] x_q, cnt_q;
	logic [IW:0] w_q;
	logic [pmib_pkg::OutW-1:0] total_q, k_q, bk_q;
	logic mid_q;
	logic [7:0] text_mem [0:pmib_pkg::MaxLen-1];
	logic [7:0] wrap_mem [0:pmib_pkg::MaxLen-1];
	logic [7:0] res_mem [0:pmib_pkg::OutMax-1];

	logic [2*IW-1:0] rd_addr, wr_addr;
	logic [CW-1:0] rd_data, wr_data;
	logic wr_en;

	pmib_cost_ram u_cost (
		.clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
	);

	logic [7:0] ca, cb;
	logic eq_ab;
	logic [CW-1:0] x_eff, y_eff;
	logic fill_eq_ok;

	assign ca = text_mem[a_q];
	assign cb = text_mem[b_q];
	assign eq_ab = (ca == cb);
	// entries with i >= j count as zero; a+1 >= b-1 when d==1 or d==2 inner
	assign x_eff = (b_q - 5'd1 > a_q) ? x_q : '0;
	assign y_eff = (b_q > a_q + 5'd1) ? rd_data : '0;
	assign fill_eq_ok = (b_q - 5'd1 > a_q + 5'd1);

	always_comb begin
		rd_addr = '0;
		unique case (state_q) inside
			ST_F_RDX, ST_T_RDX: begin
				if (eq_ab && state_q == ST_F_RDX) begin
					rd_addr = {a_q + 5'd1, b_q - 5'd1};
				end else begin
					rd_addr = {a_q, b_q - 5'd1};
				end
			end
			ST_F_RDY, ST_T_RDY: rd_addr = {a_q + 5'd1, b_q};
			ST_CNT: rd_addr = {5'd0, b_q};
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		logic [CW-1:0] mn;
		mn = (x_eff < y_eff) ? x_eff : y_eff;
		wr_en = (state_q == ST_F_WR);
		wr_addr = {a_q, b_q};
		if (eq_ab) begin
			wr_data = fill_eq_ok ? x_q : '0;
		end else begin
			wr_data = mn + 5'd1;
		end
	end

	logic in_acc;
	assign in_stall = (state_q != ST_LOAD);
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_acc && len_q < pmib_pkg::LenW'(pmib_pkg::MaxLen)) begin
			text_mem[len_q[IW-1:0]] <= in_data.in_char;
		end
		if (state_q == ST_T_DEC) begin
			wrap_mem[w_q[IW-1:0]] <= (eq_ab || !(x_eff <= y_eff)) ? ca : cb;
		end
		if (state_q == ST_BUILD) begin
			if (k_q < pmib_pkg::OutW'(w_q)) begin
				res_mem[total_q] <= wrap_mem[k_q[IW-1:0]];
			end else if (mid_q) begin
				res_mem[total_q] <= ca;
			end else begin
				res_mem[total_q] <= wrap_mem[bk_q[IW-1:0] - 5'd1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			len_q <= '0;
			d_q <= '0;
			a_q <= '0;
			b_q <= '0;
			x_q <= '0;
			cnt_q <= '0;
			w_q <= '0;
			total_q <= '0;
			k_q <= '0;
			bk_q <= '0;
			mid_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						logic [pmib_pkg::LenW-1:0] nl;
						nl = (len_q < pmib_pkg::LenW'(pmib_pkg::MaxLen)) ? len_q + 6'd1 : len_q;
						len_q <= in_data.in_last ? '0 : nl;
						if (in_data.in_last) begin
							if (nl == 6'd0) begin
								state_q <= ST_LOAD;
							end else if (nl == 6'd1) begin
								cnt_q <= '0;
								a_q <= '0;
								b_q <= '0;
								w_q <= '0;
								state_q <= ST_T_DEC;
							end else begin
								d_q <= 5'd1;
								a_q <= '0;
								b_q <= 5'd1;
								bk_q <= pmib_pkg::OutW'(nl - 6'd1);
								state_q <= ST_F_RDX;
							end
						end
					end
				end
				ST_F_RDX: state_q <= ST_F_RDY;
				ST_F_RDY: begin
					x_q <= rd_data;
					state_q <= ST_F_WR;
				end
				ST_F_WR: begin
					if (pmib_pkg::OutW'(b_q) == bk_q) begin
						if (pmib_pkg::OutW'(d_q) == bk_q) begin
							state_q <= ST_CNT;
						end else begin
							d_q <= d_q + 5'd1;
							a_q <= '0;
							b_q <= d_q + 5'd1;
							state_q <= ST_F_RDX;
						end
					end else begin
						a_q <= a_q + 5'd1;
						b_q <= b_q + 5'd1;
						state_q <= ST_F_RDX;
					end
				end
				ST_CNT: state_q <= ST_CNT2;
				ST_CNT2: begin
					cnt_q <= rd_data;
					a_q <= '0;
					w_q <= '0;
					state_q <= ST_T_RDX;
				end
				ST_T_RDX: state_q <= ST_T_RDY;
				ST_T_RDY: begin
					x_q <= rd_data;
					state_q <= ST_T_DEC;
				end
				ST_T_DEC: begin
					if (a_q < b_q) begin
						w_q <= w_q + 6'd1;
						if (eq_ab) begin
							a_q <= a_q + 5'd1;
							b_q <= b_q - 5'd1;
							state_q <= (a_q + 5'd1 < b_q - 5'd1) ? ST_T_RDX : ST_T_DEC;
						end else if (x_eff <= y_eff) begin
							b_q <= b_q - 5'd1;
							state_q <= (a_q < b_q - 5'd1) ? ST_T_RDX : ST_T_DEC;
						end else begin
							a_q <= a_q + 5'd1;
							state_q <= (a_q + 5'd1 < b_q) ? ST_T_RDX : ST_T_DEC;
						end
					end else begin
						mid_q <= (a_q == b_q);
						k_q <= '0;
						bk_q <= pmib_pkg::OutW'(w_q);
						total_q <= '0;
						state_q <= ST_BUILD;
					end
				end
				ST_BUILD: begin
					total_q <= total_q + 6'd1;
					if (k_q < pmib_pkg::OutW'(w_q)) begin
						k_q <= k_q + 6'd1;
					end else if (mid_q) begin
						mid_q <= 1'b0;
					end else begin
						bk_q <= bk_q - 6'd1;
					end
					if ((k_q == pmib_pkg::OutW'(w_q)) && !mid_q && bk_q <= 6'd1
						|| (k_q == pmib_pkg::OutW'(w_q)) && mid_q && w_q == '0) begin
						k_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid || !out_stall) begin
						if (k_q < total_q) begin
							out_valid <= 1'b1;
							out_data.out_char <= res_mem[k_q];
							out_data.insert_count <= cnt_q;
							out_data.out_last <= (k_q + 6'd1 == total_q);
							k_q <= k_q + 6'd1;
						end else begin
							out_valid <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

[verif/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 20000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	pmib_pkg::in_beat_t  in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	pmib_pkg::out_beat_t out_data;

	palindrome_min_insertion_builder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #2 clk = ~clk;

	logic [7:0]          text_q[$];
	pmib_pkg::out_beat_t pal_q[$];
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  fail_cnt = 0;
	int                  idle_cycles = 0;

	function automatic void predict_palindrome(input logic [7:0] ch, input logic last);
		logic [pmib_pkg::CostW-1:0] cost[pmib_pkg::MaxLen][pmib_pkg::MaxLen];
		logic [7:0]                 s[pmib_pkg::MaxLen];
		logic [7:0]                 wrap[$];
		logic [pmib_pkg::CostW-1:0] x, y, cnt;
		int                         n, a, b;
		pmib_pkg::out_beat_t        o;
		if (text_q.size() < pmib_pkg::MaxLen)
			text_q = {text_q, ch};
		if (!last)
			return;
		n = text_q.size();
		if (n == 0)
			return;
		foreach (s[i]) s[i] = (i < n) ? text_q[i] : 8'h00;
		text_q.delete();
		foreach (cost[i, j]) cost[i][j] = '0;
		for (int d = 1; d < n; d++) begin
			for (a = 0; a + d < n; a++) begin
				b = a + d;
				if (s[a] == s[b]) begin
					cost[a][b] = (a + 1 < b - 1) ? cost[a + 1][b - 1] : '0;
				end else begin
					x = cost[a][b - 1];
					y = cost[a + 1][b];
					cost[a][b] = ((x < y) ? x : y) + 1'b1;
				end
			end
		end
		cnt = cost[0][n - 1];
		a = 0;
		b = n - 1;
		while (a < b) begin
			if (s[a] == s[b]) begin
				wrap = {wrap, s[a]};
				a++;
				b--;
			end else if (cost[a][b - 1] <= cost[a + 1][b]) begin
				wrap = {wrap, s[b]};
				b--;
			end else begin
				wrap = {wrap, s[a]};
				a++;
			end
		end
		o.insert_count = cnt;
		o.out_last = 1'b0;
		foreach (wrap[k]) begin
			o.out_char = wrap[k];
			pal_q = {pal_q, o};
		end
		if (a == b) begin
			o.out_char = s[a];
			pal_q = {pal_q, o};
		end
		for (int k = wrap.size() - 1; k >= 0; k--) begin
			o.out_char = wrap[k];
			pal_q = {pal_q, o};
		end
		pal_q[pal_q.size() - 1].out_last = 1'b1;
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{in_char: ch, in_last: last};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_palindrome(ch, last);
	endtask

	task automatic send_string(input logic [7:0] str[$]);
		foreach (str[i])
			send_char(str[i], i == str.size() - 1);
	endtask

	task automatic send_random_string(input int len, input int alpha);
		logic [7:0] str[$];
		for (int i = 0; i < len; i++)
			str = {str, (alpha >= 256 ? 8'($urandom) : 8'($urandom_range(alpha - 1)) + 8'h61)};
		send_string(str);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pal_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("palindrome_min_insertion_builder verification failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pal_q.size() == 0) begin
				$error("unexpected beat char=%0h", out_data.out_char);
				fail_cnt++;
			end else begin
				if (out_data.out_char !== pal_q[0].out_char) begin
					$error("out_char exp %0h got %0h", pal_q[0].out_char, out_data.out_char);
					fail_cnt++;
				end
				if (out_data.insert_count !== pal_q[0].insert_count) begin
					$error("insert_count exp %0d got %0d", pal_q[0].insert_count,
						out_data.insert_count);
					fail_cnt++;
				end
				if (out_data.out_last !== pal_q[0].out_last) begin
					$error("out_last exp %0b got %0b", pal_q[0].out_last, out_data.out_last);
					fail_cnt++;
				end
				void'(pal_q.pop_front());
			end
		end
	end

	task automatic test_directed();
		logic [7:0] str[$];
		send_string('{8'h00});
		send_string('{8'hff, 8'hff});
		send_string('{8'h61, 8'h62});
		send_string('{8'h61, 8'h62, 8'h61});
		send_string('{8'h61, 8'h62, 8'h63});
		send_string('{8'h55, 8'haa, 8'h0f, 8'hf0});
		wait_drained();
		// more than MAX_LEN chars; the last flag rides on a dropped beat
		for (int i = 0; i < pmib_pkg::MaxLen + 3; i++)
			str = {str, 8'($urandom)};
		send_string(str);
		wait_drained();
	endtask

	task automatic test_random(input int items);
		int sent;
		int len;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(pmib_pkg::MaxLen, 20)
				: $urandom_range(8, 1);
			send_random_string(len, ($urandom_range(3) == 0) ? 256 : $urandom_range(4, 2));
			sent += len;
			if ($urandom_range(7) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 29;
		recv_idle_pct = 74;
		test_random(22);
		send_idle_pct = 74;
		recv_idle_pct = 29;
		test_random(22);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(22);
		wait_drained();
		repeat (50) @(posedge clk);
		if (fail_cnt == 0 && pal_q.size() == 0)
			$display("palindrome_min_insertion_builder verification clean");
		else
			$display("palindrome_min_insertion_builder verification failed");
		$finish;
	end

endmodule

[palindrome_min_insertion_builder.f]
hdl/pmib_pkg.sv
hdl/pmib_cost_ram.sv
hdl/palindrome_min_insertion_builder.sv
verif/tb.sv
